// ----- design/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, codes and control structs for the bounded deque with
// delete by value.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // fixed field widths of the channels
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // operation codes
    localparam mode_t MODE_PUSH_FRONT = 2'd0;
    localparam mode_t MODE_PUSH_BACK  = 2'd1;
    localparam mode_t MODE_REMOVE     = 2'd2;

    // result status codes
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_back;
        logic    scan_init;
        logic    scan_next;
        logic    pop_front;
        logic    shift_init;
        logic    shift_step;
        logic    dec_count;
        logic    rd_front;
        logic    rd_back;
        logic    latch_back;
        logic    set_status;
        status_t status_code;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  match;
        logic  idx_zero;
        logic  idx_last;
        logic  shift_last;
    } sts_t;

endpackage

// ----- design/bdq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_in_if
// Input channel: one operation word with mode and value.
// ----------------------------------------------------------------------------
interface bdq_in_if;

    logic                                valid;
    logic                                ready;
    bdq_pkg::mode_t                      mode;
    logic signed [bdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

// ----- design/bdq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_out_if
// Output channel: one result word with status, count, front and back values.
// ----------------------------------------------------------------------------
interface bdq_out_if;

    logic                                valid;
    logic                                ready;
    bdq_pkg::status_t                    status;
    logic [bdq_pkg::COUNT_W-1:0]         count;
    logic signed [bdq_pkg::DATA_W-1:0]   front_value;
    logic signed [bdq_pkg::DATA_W-1:0]   back_value;

    modport source (output valid, output status, output count, output front_value,
                    output back_value, input ready);
    modport sink   (input valid, input status, input count, input front_value,
                    input back_value, output ready);

endinterface

// ----- design/bdq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring storage, front position, entry count, scan index and result
// registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::ctl_t                       ctl,
    output bdq_pkg::sts_t                       sts,
    input  bdq_pkg::mode_t                      mode,
    input  logic signed [bdq_pkg::DATA_W-1:0]   value,
    output bdq_pkg::status_t                    status,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic signed [bdq_pkg::DATA_W-1:0]   front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]   back_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // ring index of a given offset from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW:0]   off);
        logic [CW+1:0] sum;
        sum = (CW+2)'(base) + (CW+2)'(off);
        if (sum >= (CW+2)'(CAPACITY))
            sum = sum - (CW+2)'(CAPACITY);
        return sum[AW-1:0];
    endfunction

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    bdq_pkg::mode_t         mode_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [AW-1:0]          front_pos_reg, front_pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    bdq_pkg::status_t       status_reg;
    logic [VALUE_WIDTH-1:0] front_val_reg;
    logic [VALUE_WIDTH-1:0] back_val_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    logic [CW:0]            idx_p1;
    logic [CW:0]            idx_p2;
    logic [CW:0]            rd_off;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          front_dec;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    assign idx_p1    = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign idx_p2    = (CW+1)'(idx_reg) + (CW+1)'(2);
    assign front_dec = (front_pos_reg == '0) ? AW'(CAPACITY - 1)
                                             : front_pos_reg - AW'(1);

    // status toward the controller
    always_comb
    begin
        sts.mode       = mode_reg;
        sts.full       = (count_reg == CW'(CAPACITY));
        sts.empty      = (count_reg == '0);
        sts.match      = (rd_data_reg == val_reg);
        sts.idx_zero   = (idx_reg == '0);
        sts.idx_last   = (idx_p1 == (CW+1)'(count_reg));
        sts.shift_last = (idx_p2 >= (CW+1)'(count_reg));
    end

    // read offset select
    always_comb
    begin
        rd_off = '0;
        if (ctl.scan_init || ctl.rd_front)
            rd_off = '0;
        else if (ctl.scan_next || ctl.shift_init)
            rd_off = idx_p1;
        else if (ctl.shift_step)
            rd_off = idx_p2;
        else if (ctl.rd_back)
            rd_off = (count_reg == '0) ? '0 : (CW+1)'(count_reg) - (CW+1)'(1);
    end

    assign rd_addr = slot_of(front_pos_reg, rd_off);

    // write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        if (ctl.push_front)
        begin
            wr_en   = 1'b1;
            wr_addr = front_dec;
        end
        else if (ctl.push_back)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(front_pos_reg, (CW+1)'(count_reg));
        end
        else if (ctl.shift_step)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(front_pos_reg, (CW+1)'(idx_reg));
            wr_data = rd_data_reg;
        end
    end

    // entry storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // ring position and count
    always_comb
    begin
        front_pos_next = front_pos_reg;
        count_next     = count_reg;
        if (ctl.push_front)
        begin
            front_pos_next = front_dec;
            count_next     = count_reg + CW'(1);
        end
        else if (ctl.push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop_front)
        begin
            count_next     = count_reg - CW'(1);
            front_pos_next = (count_reg == CW'(1)) ? '0
                                                   : slot_of(front_pos_reg, (CW+1)'(1));
        end
        else if (ctl.dec_count)
        begin
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
                front_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_pos_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            front_pos_reg <= front_pos_next;
            count_reg     <= count_next;
        end
    end

    // scan index
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.scan_init)
            idx_next = '0;
        else if (ctl.scan_next || ctl.shift_step)
            idx_next = idx_p1[CW-1:0];
    end

    // operation word and result registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.load)
        begin
            mode_reg <= mode;
            val_reg  <= VALUE_WIDTH'($unsigned(value));
        end
        if (ctl.set_status)
            status_reg <= ctl.status_code;
        if (ctl.rd_back)
            front_val_reg <= (count_reg == '0) ? '0 : rd_data_reg;
        if (ctl.latch_back)
            back_val_reg <= (count_reg == '0) ? '0 : rd_data_reg;
    end

    assign status      = status_reg;
    assign count       = bdq_pkg::COUNT_W'(count_reg);
    assign front_value = $signed(bdq_pkg::DATA_W'(front_val_reg));
    assign back_value  = $signed(bdq_pkg::DATA_W'(back_val_reg));

endmodule

// ----- design/bdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for push, scan, compaction and result read-out.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bdq_pkg::sts_t sts,
    output bdq_pkg::ctl_t ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_RD_FRONT = 3'd4;
    localparam logic [2:0] S_RD_BACK  = 3'd5;
    localparam logic [2:0] S_LATCH    = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.set_status  = 1'b1;
                ctl.status_code = bdq_pkg::ST_DONE;
                state_next      = S_RD_FRONT;
                case (sts.mode)
                    bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK:
                    begin
                        if (sts.full)
                            ctl.status_code = bdq_pkg::ST_FULL;
                        else if (sts.mode == bdq_pkg::MODE_PUSH_FRONT)
                            ctl.push_front = 1'b1;
                        else
                            ctl.push_back = 1'b1;
                    end
                    bdq_pkg::MODE_REMOVE:
                    begin
                        if (sts.empty)
                            ctl.status_code = bdq_pkg::ST_EMPTY;
                        else
                        begin
                            ctl.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        ctl.status_code = bdq_pkg::ST_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = bdq_pkg::ST_DONE;
                    if (sts.idx_zero)
                    begin
                        ctl.pop_front = 1'b1;
                        state_next    = S_RD_FRONT;
                    end
                    else if (sts.idx_last)
                    begin
                        ctl.dec_count = 1'b1;
                        state_next    = S_RD_FRONT;
                    end
                    else
                    begin
                        ctl.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else if (sts.idx_last)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = bdq_pkg::ST_NOT_FOUND;
                    state_next      = S_RD_FRONT;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (sts.shift_last)
                begin
                    ctl.dec_count = 1'b1;
                    state_next    = S_RD_FRONT;
                end
            end
            S_RD_FRONT:
            begin
                ctl.rd_front = 1'b1;
                state_next   = S_RD_BACK;
            end
            S_RD_BACK:
            begin
                ctl.rd_back = 1'b1;
                state_next  = S_LATCH;
            end
            S_LATCH:
            begin
                ctl.latch_back = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- design/bounded_deque_with_delete_by_value.sv -----
`timescale 1ns / 1ps
// push or ignored word: after accept, decode, read front, read back and latch pass before
// the result is valid; remove: decode, scan and any compaction, then read front, read
// back and latch; search and compaction take the entries in turn, set by the single read
// and single write port; one word at a time: the next word is taken only after the result is
// taken; reset clears count and front position at once; ring contents are not cleared
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_by_value
// Bounded ring deque with push front, push back and delete of the first
// matching value; each word returns status, count, front and back values.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete_by_value #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_in_if.sink    item_in,
    bdq_out_if.source result_out
);

    bdq_pkg::ctl_t ctl;
    bdq_pkg::sts_t sts;
    logic          in_ready;
    logic          out_valid;

    // controller
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_out.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath
    bdq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .mode        (item_in.mode),
        .value       (item_in.value),
        .status      (result_out.status),
        .count       (result_out.count),
        .front_value (result_out.front_value),
        .back_value  (result_out.back_value)
    );

    // handshake outputs
    assign item_in.ready    = in_ready;
    assign result_out.valid = out_valid;

endmodule

// ----- sim/bounded_deque_with_delete_by_value_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_by_value_test
// Sends push front, push back, remove and ignored words into the deque and
// checks every result word against a shadow ring kept in the testbench,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete_by_value_test;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int DEPTH        = 16;
    localparam int HEAD_W       = $clog2(DEPTH);
    localparam int RANDOM_WORDS = 1525;
    localparam int FLIP_WORDS   = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    // the fourth mode code has no name in the package; the block ignores it
    localparam bdq_pkg::mode_t MODE_IGNORED = 2'd3;

    typedef logic signed [bdq_pkg::DATA_W-1:0] value_t;

    typedef struct packed {
        bdq_pkg::status_t            status;
        logic [bdq_pkg::COUNT_W-1:0] count;
        value_t                      front_value;
        value_t                      back_value;
    } result_t;

    // shadow ring and queue of result words still owed by the block
    class deque_shadow;
        value_t            ring [DEPTH];
        logic [HEAD_W-1:0] head;
        int                fill;
        result_t           awaited [$];
        int                errors;
        int                reported;

        function new();
            head     = '0;
            fill     = 0;
            errors   = 0;
            reported = 0;
        endfunction

        function logic [HEAD_W-1:0] slot(int offset);
            return head + HEAD_W'(offset);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // drop the first entry from the front that equals v, close the gap
        function bdq_pkg::status_t remove_first(value_t v);
            int i;
            int k;
            if (fill == 0)
                return bdq_pkg::ST_EMPTY;
            i = 0;
            while (i < fill && ring[slot(i)] != v)
                i++;
            if (i == fill)
                return bdq_pkg::ST_NOT_FOUND;
            if (i == 0)
                head = slot(1);
            else
                for (k = i; k + 1 < fill; k++)
                    ring[slot(k)] = ring[slot(k + 1)];
            fill--;
            if (fill == 0)
                head = '0;
            return bdq_pkg::ST_DONE;
        endfunction

        // apply an accepted input word and queue the result it owes
        function void note_word(bdq_pkg::mode_t mode, value_t v);
            result_t r;
            r.status = bdq_pkg::ST_DONE;
            case (mode)
                bdq_pkg::MODE_PUSH_FRONT:
                    if (fill >= DEPTH)
                        r.status = bdq_pkg::ST_FULL;
                    else
                    begin
                        head       = head - 1'b1;
                        ring[head] = v;
                        fill++;
                    end
                bdq_pkg::MODE_PUSH_BACK:
                    if (fill >= DEPTH)
                        r.status = bdq_pkg::ST_FULL;
                    else
                    begin
                        ring[slot(fill)] = v;
                        fill++;
                    end
                bdq_pkg::MODE_REMOVE:
                    r.status = remove_first(v);
                default:
                    ;
            endcase
            r.count = fill[bdq_pkg::COUNT_W-1:0];
            if (fill == 0)
            begin
                r.front_value = '0;
                r.back_value  = '0;
            end
            else
            begin
                r.front_value = ring[slot(0)];
                r.back_value  = ring[slot(fill - 1)];
            end
            awaited.push_back(r);
        endfunction

        function void flag(string what);
            errors++;
            if (reported < REPORT_MAX)
            begin
                reported++;
                $display("%s", what);
            end
        endfunction

        // compare a result word with the oldest one owed
        function void check_result(bdq_pkg::status_t status,
                                   logic [bdq_pkg::COUNT_W-1:0] count,
                                   value_t front_value, value_t back_value);
            result_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result word with none owed: status=%0d count=%0d front=%0d back=%0d",
                               status, count, front_value, back_value));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status || count !== want.count ||
                front_value !== want.front_value || back_value !== want.back_value)
                flag($sformatf({"result mismatch: expected status=%0d count=%0d front=%0d back=%0d,",
                                " got status=%0d count=%0d front=%0d back=%0d"},
                               want.status, want.count, want.front_value, want.back_value,
                               status, count, front_value, back_value));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;
    deque_shadow ledger = new();

    bdq_in_if  item_in ();
    bdq_out_if result_out ();

    bounded_deque_with_delete_by_value u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bounded_deque_with_delete_by_value_test: errors");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        result_out.ready <= ($urandom_range(0, 99) >= stall_pct);

    // result monitor
    always @(posedge clk)
        if (rst_n && result_out.valid === 1'b1 && result_out.ready)
            ledger.check_result(result_out.status, result_out.count,
                                result_out.front_value, result_out.back_value);

    // send one word with random gaps ahead of it; returns on a falling edge
    task automatic send_word(input bdq_pkg::mode_t mode, input value_t v);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_in.valid <= 1'b0;
            @(negedge clk);
        end
        item_in.valid <= 1'b1;
        item_in.mode  <= mode;
        item_in.value <= v;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        ledger.note_word(mode, v);
        @(negedge clk);
    endtask

    initial
    begin
        value_t         filled [DEPTH];
        value_t         pool [8];
        int             gap_of [4];
        int             stall_of [4];
        int             phase;
        int             n;
        int             roll;
        bit             filling;
        bdq_pkg::mode_t mode;
        value_t         v;

        gap_of   = '{0, 60, 0, 30};
        stall_of = '{0, 0, 60, 30};

        rst_n            = 1'b0;
        item_in.valid    = 1'b0;
        item_in.mode     = bdq_pkg::MODE_PUSH_FRONT;
        item_in.value    = '0;
        result_out.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store cases and the value extremes
        send_word(bdq_pkg::MODE_REMOVE, 32'sd5);
        send_word(MODE_IGNORED, 32'sd0);
        send_word(bdq_pkg::MODE_PUSH_BACK, 32'sh7FFFFFFF);
        send_word(bdq_pkg::MODE_PUSH_FRONT, 32'sh80000000);
        send_word(bdq_pkg::MODE_REMOVE, 32'sh00012345);
        send_word(bdq_pkg::MODE_REMOVE, 32'sh80000000);
        send_word(bdq_pkg::MODE_REMOVE, 32'sh7FFFFFFF);

        // fill to capacity from both ends, wrapping the ring
        for (n = 0; n < DEPTH; n++)
        begin
            filled[n] = (n == 0) ? 32'sd0 : (n == 1) ? -32'sd1 : value_t'($urandom);
            send_word((n % 2 == 0) ? bdq_pkg::MODE_PUSH_FRONT : bdq_pkg::MODE_PUSH_BACK,
                      filled[n]);
        end

        // pushes into a full store, then middle, back and front removal
        send_word(bdq_pkg::MODE_PUSH_FRONT, 32'sh55555555);
        send_word(bdq_pkg::MODE_PUSH_BACK, 32'shAAAAAAAA);
        send_word(MODE_IGNORED, 32'sh0F0F0F0F);
        send_word(bdq_pkg::MODE_REMOVE, filled[4]);
        send_word(bdq_pkg::MODE_REMOVE, filled[15]);
        send_word(bdq_pkg::MODE_REMOVE, filled[14]);

        // small value pool so removes hit and duplicates appear
        pool = '{32'sd0, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1,
                 value_t'($urandom), value_t'($urandom), value_t'($urandom)};

        // random words: alternate filling and draining runs in each idle pattern
        for (phase = 0; phase < 4; phase++)
        begin
            send_gap_pct = gap_of[phase];
            stall_pct    = stall_of[phase];
            for (n = 0; n < RANDOM_WORDS / 4; n++)
            begin
                filling = ((n / FLIP_WORDS) % 2) == 0;
                roll    = $urandom_range(0, 99);
                if (roll < 3)
                    mode = MODE_IGNORED;
                else if (filling)
                    mode = (roll < 38) ? bdq_pkg::MODE_PUSH_FRONT :
                           (roll < 73) ? bdq_pkg::MODE_PUSH_BACK : bdq_pkg::MODE_REMOVE;
                else
                    mode = (roll < 20) ? bdq_pkg::MODE_PUSH_FRONT :
                           (roll < 37) ? bdq_pkg::MODE_PUSH_BACK : bdq_pkg::MODE_REMOVE;
                if ($urandom_range(0, 3) == 0)
                    v = value_t'($urandom);
                else
                    v = pool[$urandom_range(0, 7)];
                send_word(mode, v);
            end
        end
        item_in.valid <= 1'b0;

        // wait for every owed word, then watch for strays
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("bounded_deque_with_delete_by_value_test: clean");
        else
            $display("bounded_deque_with_delete_by_value_test: errors");
        $finish;
    end

endmodule

// ----- bounded_deque_with_delete_by_value.f -----
design/bdq_pkg.sv
design/bdq_in_if.sv
design/bdq_out_if.sv
design/bdq_datapath.sv
design/bdq_ctrl.sv
design/bounded_deque_with_delete_by_value.sv
sim/bounded_deque_with_delete_by_value_test.sv
